### rtl/core/klps_pkg.sv
// ----------------------------------------------------------------------------
// klps_pkg
// Shared types and constants for the keypad LED pattern sequencer.
// ----------------------------------------------------------------------------
package klps_pkg;

    localparam int KEY_W    = 4;
    localparam int LED_W    = 8;
    localparam int PERIOD_W = 24;
    localparam int STEP_W   = 5;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(60000);

    // register word index
    localparam logic [0:0] REG_STEP_PERIOD = 1'b0;

    // active-low key codes
    localparam logic [KEY_W-1:0] KEY_M1 = 4'hE;
    localparam logic [KEY_W-1:0] KEY_M2 = 4'hD;
    localparam logic [KEY_W-1:0] KEY_M3 = 4'hB;
    localparam logic [KEY_W-1:0] KEY_M4 = 4'h7;

    localparam logic [LED_W-1:0] LED_OFF   = 8'h00;
    localparam logic [LED_W-1:0] WALK_LO   = 8'h01;
    localparam logic [LED_W-1:0] WALK_HI   = 8'h80;
    localparam logic [LED_W-1:0] PAT_ALT_A = 8'hAA;
    localparam logic [LED_W-1:0] PAT_ALT_B = 8'h55;
    localparam logic [LED_W-1:0] PAT_NIB_A = 8'hF0;
    localparam logic [LED_W-1:0] PAT_NIB_B = 8'h0F;

    typedef enum logic [2:0] {
        MODE_NONE  = 3'd0,
        MODE_CHASE = 3'd1,
        MODE_FILL  = 3'd2,
        MODE_ALT   = 3'd3,
        MODE_NIB   = 3'd4
    } t_mode;

endpackage

### rtl/core/klps_if.sv
// ----------------------------------------------------------------------------
// klps_if
// Valid/ready stream interfaces for keypad samples and LED results.
// ----------------------------------------------------------------------------
interface klps_key_if
    import klps_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_lines;

    modport source (output valid, output key_lines, input ready);
    modport sink   (input valid, input key_lines, output ready);
endinterface

interface klps_led_if
    import klps_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LED_W-1:0] led_pattern;

    modport source (output valid, output led_pattern, input ready);
    modport sink   (input valid, input led_pattern, output ready);
endinterface

### rtl/core/klps_cfg.sv
// ----------------------------------------------------------------------------
// klps_cfg
// APB register block holding the step period.
// ----------------------------------------------------------------------------
module klps_cfg
    import klps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    output logic [PERIOD_W-1:0] o_step_period
);

    logic [PERIOD_W-1:0] r_step_period;
    logic [0:0]          word_idx;
    logic                wr_en;

    assign word_idx = paddr[APB_AW-1:APB_AW-1];
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready
                      && (word_idx == REG_STEP_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_period <= PERIOD_RST;
        end else if (wr_en) begin
            r_step_period <= pwdata[PERIOD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (word_idx == REG_STEP_PERIOD) begin
            prdata = APB_DW'(r_step_period);
        end
    end

    assign o_step_period = r_step_period;

endmodule

### rtl/core/klps_core.sv
// ----------------------------------------------------------------------------
// klps_core
// Pattern state and per-tick update: key decode, tick counter, step logic.
// ----------------------------------------------------------------------------
module klps_core
    import klps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [PERIOD_W-1:0] i_step_period,
    output logic [LED_W-1:0]    o_led_next
);

    t_mode               r_mode,  n_mode;
    logic [PERIOD_W-1:0] r_tick,  n_tick;
    logic [STEP_W-1:0]   r_step,  n_step;
    logic [LED_W-1:0]    r_walk,  n_walk;
    logic [LED_W-1:0]    r_led,   n_led;

    t_mode               sel;
    logic [LED_W-1:0]    walk_up;
    logic [LED_W-1:0]    walk_dn;

    always_comb begin
        unique case (i_key)
            KEY_M1:  sel = MODE_CHASE;
            KEY_M2:  sel = MODE_FILL;
            KEY_M3:  sel = MODE_ALT;
            KEY_M4:  sel = MODE_NIB;
            default: sel = MODE_NONE;
        endcase
    end

    always_comb begin
        // mode select restarts the pattern
        n_mode = r_mode;
        n_tick = r_tick;
        n_step = r_step;
        n_walk = r_walk;
        n_led  = r_led;
        if (sel != MODE_NONE) begin
            n_mode = sel;
            n_tick = '0;
            n_step = '0;
            n_led  = LED_OFF;
            if (sel == MODE_CHASE || sel == MODE_FILL) begin
                n_walk = WALK_LO;
            end
        end

        walk_up = {n_walk[LED_W-2:0], 1'b0};
        walk_dn = {1'b0, n_walk[LED_W-1:1]};

        if (n_mode != MODE_NONE) begin
            if (n_tick == i_step_period) begin
                n_tick = '0;
                unique case (n_mode)
                    MODE_CHASE: begin
                        unique case (n_step[4:3])
                            2'd0: begin
                                n_led  = n_led | n_walk;
                                n_walk = (n_step[2:0] == 3'd7) ? WALK_LO : walk_up;
                            end
                            2'd1: begin
                                n_led  = n_led & ~n_walk;
                                n_walk = (n_step[2:0] == 3'd7) ? WALK_HI : walk_up;
                            end
                            2'd2: begin
                                n_led  = n_led | n_walk;
                                n_walk = (n_step[2:0] == 3'd7) ? WALK_HI : walk_dn;
                            end
                            default: begin
                                n_led  = n_led & ~n_walk;
                                n_walk = (n_step[2:0] == 3'd7) ? WALK_LO : walk_dn;
                            end
                        endcase
                        n_step = n_step + STEP_W'(1);
                    end
                    MODE_FILL: begin
                        if (n_step < STEP_W'(8)) begin
                            n_led  = n_led | n_walk;
                            n_walk = (n_step == STEP_W'(7)) ? WALK_LO : walk_up;
                            n_step = n_step + STEP_W'(1);
                        end else if (n_step >= STEP_W'(15)) begin
                            n_led  = n_led & ~n_walk;
                            n_walk = WALK_LO;
                            n_step = '0;
                        end else begin
                            n_led  = n_led & ~n_walk;
                            n_walk = walk_up;
                            n_step = n_step + STEP_W'(1);
                        end
                    end
                    MODE_ALT: begin
                        n_led  = (n_step == '0) ? PAT_ALT_A : PAT_ALT_B;
                        n_step = (n_step == '0) ? STEP_W'(1) : '0;
                    end
                    MODE_NIB: begin
                        n_led  = (n_step == '0) ? PAT_NIB_A : PAT_NIB_B;
                        n_step = (n_step == '0) ? STEP_W'(1) : '0;
                    end
                    default: begin
                        n_led = n_led;
                    end
                endcase
            end else begin
                n_tick = n_tick + PERIOD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
            r_tick <= '0;
            r_step <= '0;
            r_walk <= WALK_LO;
            r_led  <= LED_OFF;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_tick <= n_tick;
            r_step <= n_step;
            r_walk <= n_walk;
            r_led  <= n_led;
        end
    end

    assign o_led_next = n_led;

    a_walk_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_walk))
        else $error("walking bit lost its single set bit");

    a_fill_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FILL) |-> (r_step < STEP_W'(16)))
        else $error("fill chase step index out of range");

    a_alt_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ALT || r_mode == MODE_NIB) |-> (r_step < STEP_W'(2)))
        else $error("alternating pattern step index out of range");

    a_idle_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_NONE) |-> (r_led == LED_OFF && r_tick == '0))
        else $error("LEDs or counter moved with no mode selected");

endmodule

### rtl/core/keypad_led_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// keypad_led_pattern_sequencer
// Keypad-selected LED chase and alternating pattern generator.
// ----------------------------------------------------------------------------
// Each keypad transfer is one tick and yields exactly one LED transfer. The
// block takes one tick per clock cycle while the LED side is not stalled: a
// transfer lands in an input register, and the pattern state and the result
// register update when the tick moves on from it, so the LED byte is offered
// from the result register. Back-pressure on the LED side stalls both stages
// together; the input side keeps accepting while either register is free or
// the result is being drained. The step period (APB word 0) should be written
// only while no ticks are in flight.
module keypad_led_pattern_sequencer
    import klps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    klps_key_if.sink            i_key,
    klps_led_if.source          o_led,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    logic                r_in_valid;
    logic [KEY_W-1:0]    r_in_key;
    logic                r_out_valid;
    logic [LED_W-1:0]    r_out_led;

    logic                advance;
    logic                proc_en;
    logic [PERIOD_W-1:0] step_period;
    logic [LED_W-1:0]    led_next;

    klps_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_step_period (step_period)
    );

    assign advance     = !r_out_valid || o_led.ready;
    assign proc_en     = advance && r_in_valid;
    assign i_key.ready = !r_in_valid || advance;

    klps_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (proc_en),
        .i_key         (r_in_key),
        .i_step_period (step_period),
        .o_led_next    (led_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_key.ready) begin
                r_in_valid <= i_key.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key.valid && i_key.ready) begin
            r_in_key <= i_key.key_lines;
        end
        if (proc_en) begin
            r_out_led <= led_next;
        end
    end

    assign o_led.valid       = r_out_valid;
    assign o_led.led_pattern = r_out_led;

    a_tick_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_en |=> (r_out_valid && r_out_led == $past(led_next)))
        else $error("processed tick did not reach the result register");

endmodule

### sim/led_sequence_tb_pkg.sv
// ----------------------------------------------------------------------------
// led_sequence_tb_pkg
// Scoreboard for the keypad LED pattern sequencer testbench.
// ----------------------------------------------------------------------------
// Tracks mode, tick counter, step index, walking bit and LED byte for every
// accepted keypad transfer, and queues the LED byte each one must produce.
package led_sequence_tb_pkg;
    import klps_pkg::*;

    class led_sequence_scoreboard;
        logic [PERIOD_W-1:0] step_period;
        t_mode               mode;
        logic [PERIOD_W-1:0] tick_count;
        logic [STEP_W-1:0]   step_index;
        logic [LED_W-1:0]    walk_bit;
        logic [LED_W-1:0]    leds;
        logic [LED_W-1:0]    expected_leds[$];
        int unsigned         mismatches;

        function new();
            step_period = PERIOD_RST;
            mode        = MODE_NONE;
            tick_count  = '0;
            step_index  = '0;
            walk_bit    = WALK_LO;
            leds        = LED_OFF;
            mismatches  = 0;
        endfunction

        function void set_period(logic [PERIOD_W-1:0] value);
            step_period = value;
        endfunction

        function int pending();
            return expected_leds.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // one pattern step of the active mode
        function void advance_pattern();
            case (mode)
                MODE_CHASE: begin
                    if (step_index < 8) begin
                        leds     = leds | walk_bit;
                        walk_bit = walk_bit << 1;
                        if (step_index == 7) walk_bit = WALK_LO;
                    end else if (step_index < 16) begin
                        leds     = leds & ~walk_bit;
                        walk_bit = walk_bit << 1;
                        if (step_index == 15) walk_bit = WALK_HI;
                    end else if (step_index < 24) begin
                        leds     = leds | walk_bit;
                        walk_bit = walk_bit >> 1;
                        if (step_index == 23) walk_bit = WALK_HI;
                    end else begin
                        leds     = leds & ~walk_bit;
                        walk_bit = walk_bit >> 1;
                        if (step_index == 31) walk_bit = WALK_LO;
                    end
                    step_index = step_index + 1'b1;
                end
                MODE_FILL: begin
                    if (step_index < 8) begin
                        leds       = leds | walk_bit;
                        walk_bit   = walk_bit << 1;
                        if (step_index == 7) walk_bit = WALK_LO;
                        step_index = step_index + 1'b1;
                    end else begin
                        leds     = leds & ~walk_bit;
                        walk_bit = walk_bit << 1;
                        if (step_index >= 15) begin
                            step_index = '0;
                            walk_bit   = WALK_LO;
                        end else begin
                            step_index = step_index + 1'b1;
                        end
                    end
                end
                MODE_ALT: begin
                    leds       = (step_index == 0) ? PAT_ALT_A : PAT_ALT_B;
                    step_index = (step_index == 0) ? STEP_W'(1) : '0;
                end
                MODE_NIB: begin
                    leds       = (step_index == 0) ? PAT_NIB_A : PAT_NIB_B;
                    step_index = (step_index == 0) ? STEP_W'(1) : '0;
                end
                default: ;
            endcase
        endfunction

        function void note_key(logic [KEY_W-1:0] key);
            t_mode sel;
            case (key)
                KEY_M1:  sel = MODE_CHASE;
                KEY_M2:  sel = MODE_FILL;
                KEY_M3:  sel = MODE_ALT;
                KEY_M4:  sel = MODE_NIB;
                default: sel = MODE_NONE;
            endcase
            if (sel != MODE_NONE) begin
                mode       = sel;
                tick_count = '0;
                step_index = '0;
                leds       = LED_OFF;
                if (sel == MODE_CHASE || sel == MODE_FILL) walk_bit = WALK_LO;
            end
            if (mode != MODE_NONE) begin
                if (tick_count == step_period) begin
                    advance_pattern();
                    tick_count = '0;
                end else begin
                    tick_count = tick_count + 1'b1;
                end
            end
            expected_leds.push_back(leds);
        endfunction

        task check_led(logic [LED_W-1:0] got);
            logic [LED_W-1:0] want;
            if (expected_leds.size() == 0) begin
                report($sformatf("LED transfer 0x%02h with nothing expected", got));
            end else begin
                want = expected_leds.pop_front();
                if (got !== want)
                    report($sformatf("led_pattern 0x%02h, expected 0x%02h", got, want));
            end
        endtask
    endclass

endpackage

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keypad LED pattern sequencer.
// ----------------------------------------------------------------------------
// Drives keypad ticks with random gaps and LED back-pressure, programs the
// step period over APB between phases (zero, the maximum and values between),
// and checks every LED transfer against a cycle-free model of the patterns.
module testbench
    import klps_pkg::*, led_sequence_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KEY_W-1:0] KEY_NONE = 4'hF;
    localparam int               CYCLE_LIMIT = 400000;
    localparam int               PHASE_ITEMS = 75;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic              quiet;
    int unsigned       cycles;

    led_sequence_scoreboard sb;

    klps_key_if key_if ();
    klps_led_if led_if ();

    keypad_led_pattern_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if),
        .o_led   (led_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // transfer monitor: both sides sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (key_if.valid && key_if.ready) sb.note_key(key_if.key_lines);
            if (led_if.valid && led_if.ready) sb.check_led(led_if.led_pattern);
        end
    end

    // LED side back-pressure
    initial begin
        led_if.ready <= 1'b0;
        repeat (10) @(posedge i_clk);
        forever begin
            if (quiet) begin
                led_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                led_if.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
                if ($urandom_range(0, 2) == 0) begin
                    led_if.ready <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge i_clk);
                end
            end
        end
    end

    task send_key(logic [KEY_W-1:0] key);
        int gap;
        key_if.valid     <= 1'b1;
        key_if.key_lines <= key;
        @(posedge i_clk);
        while (!key_if.ready) @(posedge i_clk);
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        if (gap > 0) begin
            key_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every LED transfer still owed
    task drain();
        key_if.valid <= 1'b0;
        // let the monitor note the last accepted tick first
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_period(logic [PERIOD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_STEP_PERIOD, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_period(value);
        @(posedge i_clk);
        // read back
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[PERIOD_W-1:0] !== value)
            sb.report($sformatf("step_period reads 0x%06h, wrote 0x%06h",
                                prdata[PERIOD_W-1:0], value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // mode selections followed by runs of released keys, with some noise
    task run_patterns(int n_items, logic [PERIOD_W-1:0] per);
        logic [KEY_W-1:0] mode_keys [4];
        logic [KEY_W-1:0] k;
        int               sent;
        int               span;
        int               run;
        int               held;
        mode_keys = '{KEY_M1, KEY_M2, KEY_M3, KEY_M4};
        sent = $urandom_range(1, 6);
        // released keys first, so the count carries over from the last phase
        repeat (sent) send_key(KEY_NONE);
        span = (per < 4) ? 34 * (int'(per) + 1) : 140;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                k    = mode_keys[$urandom_range(0, 3)];
                held = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1;
                repeat (held) send_key(k);
                run  = $urandom_range(1, span);
                // keep the phase near its item budget
                if (sent + held + run > n_items)
                    run = (n_items > sent + held) ? n_items - sent - held : 1;
                for (int i = 0; i < run; i++) begin
                    if ($urandom_range(0, 9) == 0) send_key(KEY_W'($urandom_range(0, 15)));
                    else send_key(KEY_NONE);
                end
                sent += held + run;
            end else begin
                run = $urandom_range(1, 3);
                repeat (run) send_key(KEY_W'($urandom_range(0, 15)));
                sent += run;
            end
        end
    endtask

    initial begin
        logic [PERIOD_W-1:0] periods [7];
        sb               = new();
        cycles           = 0;
        quiet            = 1'b0;
        i_rst_n          <= 1'b0;
        key_if.valid     <= 1'b0;
        key_if.key_lines <= KEY_NONE;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        periods = '{24'd1, 24'hFFFFFF, 24'd3, 24'd0, 24'd2,
                    PERIOD_W'($urandom_range(4, 9)), 24'd0};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no mode yet: nothing counts and unmatched codes are ignored until M1 selects the chase
        send_key(KEY_NONE);
        send_key(4'h0);
        send_key(KEY_M1);
        send_key(KEY_NONE);
        drain();
        write_period('0);

        // period zero: a step on every tick
        send_key(KEY_M1);
        repeat (8) send_key(KEY_NONE);
        send_key(KEY_M1);
        send_key(KEY_M1);
        send_key(KEY_M2);
        repeat (2) send_key(KEY_NONE);
        send_key(KEY_M3);
        repeat (2) send_key(KEY_NONE);
        send_key(KEY_M4);
        repeat (2) send_key(KEY_NONE);
        send_key(4'h9);
        send_key(4'h0);

        for (int p = 0; p < 7; p++) begin
            drain();
            write_period(periods[p]);
            if (p == 6) quiet = 1'b1;
            run_patterns(PHASE_ITEMS, periods[p]);
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/klps_pkg.sv
rtl/core/klps_if.sv
rtl/core/klps_cfg.sv
rtl/core/klps_core.sv
rtl/core/keypad_led_pattern_sequencer.sv
sim/led_sequence_tb_pkg.sv
sim/testbench.sv
